// ===== design/acd_pkg.sv =====
`timescale 1ns / 1ps

package acd_pkg;

  localparam int WINDOW    = 64;
  localparam int IDX_W     = $clog2(WINDOW);
  localparam int FILL_W    = $clog2(WINDOW + 1);
  localparam int FRAC_BITS = 10;

  // reciprocal of 100 for operands below 2^28, and for small operands below 2^17
  localparam logic [28:0] RECIP100_HI = 29'd343597384;
  localparam logic [17:0] RECIP100_LO = 18'd167773;

  localparam logic [1:0] CFG_SEED_LENGTH = 2'd0;
  localparam logic [1:0] CFG_MAX_GAP     = 2'd1;
  localparam logic [1:0] CFG_BAND_WIDTH  = 2'd2;

  localparam logic [7:0]  SEED_RESET = 8'd17;
  localparam logic [19:0] GAP_RESET  = 20'd10000;
  localparam logic [6:0]  BAND_RESET = 7'd64;

  typedef struct packed {
    logic [31:0] q_begin;
    logic [31:0] q_end;
    logic [31:0] t_begin;
    logic [31:0] t_end;
    logic        new_read;
  } anchor_in_t;

  typedef struct packed {
    logic signed [31:0] chain_score;
    logic [6:0]         pred_distance;
  } chain_out_t;

  typedef struct packed {
    logic [31:0]        qb;
    logic [31:0]        qe;
    logic [31:0]        tb;
    logic [31:0]        te;
    logic signed [31:0] score;
  } entry_t;

  // per-candidate side data carried down the scoring pipeline
  typedef struct packed {
    logic               vld;
    logic               rej;
    logic [6:0]         cand_d;
    logic signed [31:0] score;
    logic [7:0]         m;
    logic [31:0]        ov;
    logic               gnz;
  } carry_t;

  typedef struct packed {
    logic               vld;
    logic               rej;
    logic [6:0]         cand_d;
    logic signed [31:0] s;
  } prop_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE
  } state_t;

  function automatic logic [16:0] log_tab(input logic [4:0] k);
    logic [16:0] v;
    unique case (k)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd5732;
      5'd2:    v = 17'd11136;
      5'd3:    v = 17'd16248;
      5'd4:    v = 17'd21098;
      5'd5:    v = 17'd25711;
      5'd6:    v = 17'd30109;
      5'd7:    v = 17'd34312;
      5'd8:    v = 17'd38336;
      5'd9:    v = 17'd42196;
      5'd10:   v = 17'd45904;
      5'd11:   v = 17'd49472;
      5'd12:   v = 17'd52911;
      5'd13:   v = 17'd56229;
      5'd14:   v = 17'd59434;
      5'd15:   v = 17'd62534;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] lead_one(input logic [19:0] g);
    logic [4:0] e;
    e = 5'd0;
    for (int i = 0; i < 20; i++) begin
      if (g[i]) e = 5'(i);
    end
    return e;
  endfunction

endpackage

// ===== design/acd_window.sv =====
`timescale 1ns / 1ps

module acd_window (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [acd_pkg::IDX_W-1:0] wr_addr,
  input  acd_pkg::entry_t           wr_data,
  input  logic                      rd_en,
  input  logic [acd_pkg::IDX_W-1:0] rd_addr,
  output acd_pkg::entry_t           rd_data
);

  acd_pkg::entry_t mem [acd_pkg::WINDOW];
  acd_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/acd_prop.sv =====
`timescale 1ns / 1ps

module acd_prop (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [6:0]         in_dist,
  input  acd_pkg::entry_t    pred,
  input  acd_pkg::entry_t    cur,
  input  logic [7:0]         seed,
  input  logic [19:0]        max_gap,
  output acd_pkg::prop_res_t res,
  output logic               busy
);

  // stage 1: differences
  logic               s1_vld_r, s1_ord_r;
  logic [6:0]         s1_dist_r;
  logic signed [31:0] s1_score_r;
  logic [32:0]        s1_dqb_r, s1_dqe_r, s1_dtb_r, s1_dte_r;
  logic [31:0]        s1_ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_dist_r  <= in_dist;
    s1_score_r <= pred.score;
    s1_ord_r   <= (pred.qe >= cur.qe);
    s1_dqb_r   <= {1'b0, cur.qb} - {1'b0, pred.qb};
    s1_dqe_r   <= {1'b0, cur.qe} - {1'b0, pred.qe};
    s1_dtb_r   <= {1'b0, cur.tb} - {1'b0, pred.tb};
    s1_dte_r   <= {1'b0, cur.te} - {1'b0, pred.te};
    s1_ov_r    <= (pred.qe > cur.qb) ? pred.qe - cur.qb : 32'd0;
  end

  // stage 2: gaps, rejection, matched length
  logic [31:0]     ql, tl, mn;
  logic            ql_inf, tl_inf;
  logic [19:0]     g;
  acd_pkg::carry_t c2;
  logic [19:0]     s2_g_r;

  always_comb begin
    ql_inf = s1_dqb_r[32] & s1_dqe_r[32];
    tl_inf = s1_dtb_r[32] & s1_dte_r[32];
    if (s1_dqb_r[32]) begin
      ql = s1_dqe_r[31:0];
    end else if (s1_dqe_r[32]) begin
      ql = s1_dqb_r[31:0];
    end else begin
      ql = (s1_dqb_r[31:0] < s1_dqe_r[31:0]) ? s1_dqb_r[31:0] : s1_dqe_r[31:0];
    end
    if (s1_dtb_r[32]) begin
      tl = s1_dte_r[31:0];
    end else if (s1_dte_r[32]) begin
      tl = s1_dtb_r[31:0];
    end else begin
      tl = (s1_dtb_r[31:0] < s1_dte_r[31:0]) ? s1_dtb_r[31:0] : s1_dte_r[31:0];
    end
    g  = (ql > tl) ? 20'(ql - tl) : 20'(tl - ql);
    mn = (ql < tl) ? ql : tl;
    c2.vld    = s1_vld_r;
    c2.rej    = s1_ord_r | ql_inf | tl_inf | (ql > {12'd0, max_gap})
              | (tl > {12'd0, max_gap});
    c2.cand_d = s1_dist_r;
    c2.score  = s1_score_r;
    c2.m      = (mn < {24'd0, seed}) ? mn[7:0] : seed;
    c2.ov     = s1_ov_r;
    c2.gnz    = (g != 20'd0);
  end

  acd_pkg::carry_t c_r [2:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 2; i <= 8; i++) c_r[i].vld <= 1'b0;
    end else begin
      c_r[2].vld <= c2.vld;
      for (int i = 3; i <= 8; i++) c_r[i].vld <= c_r[i-1].vld;
    end
    c_r[2].rej    <= c2.rej;
    c_r[2].cand_d <= c2.cand_d;
    c_r[2].score  <= c2.score;
    c_r[2].m      <= c2.m;
    c_r[2].ov     <= c2.ov;
    c_r[2].gnz    <= c2.gnz;
    for (int i = 3; i <= 8; i++) begin
      c_r[i].rej    <= c_r[i-1].rej;
      c_r[i].cand_d <= c_r[i-1].cand_d;
      c_r[i].score  <= c_r[i-1].score;
      c_r[i].m      <= c_r[i-1].m;
      c_r[i].ov     <= c_r[i-1].ov;
      c_r[i].gnz    <= c_r[i-1].gnz;
    end
  end

  always_ff @(posedge clk) begin
    s2_g_r <= g;
  end

  // stage 3: seed * gap and leading one
  logic [27:0] s3_x_r;
  logic [4:0]  s3_e_r;
  logic [19:0] s3_g_r;

  always_ff @(posedge clk) begin
    s3_x_r <= 28'(seed) * 28'(s2_g_r);
    s3_e_r <= acd_pkg::lead_one(s2_g_r);
    s3_g_r <= s2_g_r;
  end

  // stage 4: reciprocal partial products, normalise and look up
  logic [23:0] gn;
  logic [42:0] s4_phi_r, s4_plo_r;
  logic [27:0] s4_x_r;
  logic [4:0]  s4_e_r;
  logic [16:0] s4_lo_r;
  logic [15:0] s4_dif_r;
  logic [18:0] s4_rem_r;
  logic [16:0] lo4, hi4;

  always_comb begin
    gn  = 24'(s3_g_r) << (5'd23 - s3_e_r);
    lo4 = acd_pkg::log_tab({1'b0, gn[22:19]});
    hi4 = acd_pkg::log_tab(5'({1'b0, gn[22:19]} + 5'd1));
  end

  always_ff @(posedge clk) begin
    s4_phi_r <= 43'(s3_x_r[27:14]) * 43'(acd_pkg::RECIP100_HI);
    s4_plo_r <= 43'(s3_x_r[13:0]) * 43'(acd_pkg::RECIP100_HI);
    s4_x_r   <= s3_x_r;
    s4_e_r   <= s3_e_r;
    s4_lo_r  <= lo4;
    s4_dif_r <= 16'(hi4 - lo4);
    s4_rem_r <= gn[18:0];
  end

  // stage 5: quotient by 100 and interpolation product
  logic [56:0] qsum;
  logic [21:0] s5_q_r;
  logic [27:0] s5_x_r;
  logic [34:0] s5_int_r;
  logic [4:0]  s5_e_r;
  logic [16:0] s5_lo_r;

  assign qsum = {s4_phi_r, 14'd0} + 57'(s4_plo_r);

  always_ff @(posedge clk) begin
    s5_q_r   <= qsum[56:35];
    s5_x_r   <= s4_x_r;
    s5_int_r <= 35'(s4_dif_r) * 35'(s4_rem_r);
    s5_e_r   <= s4_e_r;
    s5_lo_r  <= s4_lo_r;
  end

  // stage 6: remainder and log term
  logic [27:0] rdiff;
  logic [21:0] logv, logr;
  logic [21:0] s6_q_r;
  logic [6:0]  s6_r_r;
  logic [14:0] s6_logt_r;

  always_comb begin
    rdiff = s5_x_r - 28'(s5_q_r * 29'd100);
    logv  = {1'b0, s5_e_r, 16'd0} + 22'(s5_lo_r) + 22'(s5_int_r[34:19]);
    logr  = logv + 22'd64;
  end

  always_ff @(posedge clk) begin
    s6_q_r    <= s5_q_r;
    s6_r_r    <= rdiff[6:0];
    s6_logt_r <= logr[21:7];
  end

  // stage 7: rounded remainder share
  logic [16:0] vrem;
  logic [21:0] s7_q_r;
  logic [34:0] s7_pv_r;
  logic [14:0] s7_logt_r;

  assign vrem = {s6_r_r, 10'd0} + 17'd50;

  always_ff @(posedge clk) begin
    s7_q_r    <= s6_q_r;
    s7_pv_r   <= 35'(vrem) * 35'(acd_pkg::RECIP100_LO);
    s7_logt_r <= s6_logt_r;
  end

  // stage 8: gap cost
  logic [32:0] s8_cost_r;

  always_ff @(posedge clk) begin
    if (c_r[7].gnz) begin
      s8_cost_r <= 33'({s7_q_r, 10'd0}) + 33'(s7_pv_r[34:24]) + 33'(s7_logt_r);
    end else begin
      s8_cost_r <= 33'd0;
    end
  end

  // stage 9: proposal with saturation
  logic signed [45:0] sum;
  logic signed [31:0] sat;
  acd_pkg::prop_res_t res_r;

  always_comb begin
    sum = $signed({{14{c_r[8].score[31]}}, c_r[8].score})
        + $signed({28'd0, c_r[8].m, 10'd0})
        - $signed({13'd0, s8_cost_r})
        + $signed({4'd0, c_r[8].ov, 10'd0});
    if (!sum[45] && (sum[44:31] != 14'd0)) begin
      sat = 32'sh7FFFFFFF;
    end else if (sum[45] && (sum[44:31] != 14'h3FFF)) begin
      sat = 32'sh80000000;
    end else begin
      sat = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.vld <= 1'b0;
    end else begin
      res_r.vld <= c_r[8].vld;
    end
    res_r.rej    <= c_r[8].rej;
    res_r.cand_d <= c_r[8].cand_d;
    res_r.s      <= sat;
  end

  always_comb begin
    busy = s1_vld_r | res_r.vld;
    for (int i = 2; i <= 8; i++) busy = busy | c_r[i].vld;
  end

  assign res = res_r;

endmodule

// ===== design/anchor_chaining_dp.sv =====
`timescale 1ns / 1ps

// channel   ports                               transaction
// in        in_valid, in_stall, in_data         one seed anchor
// out       out_valid, out_stall, out_data      score and predecessor distance
// cfg       cfg_we, cfg_addr, cfg_wdata         register write
//
// One anchor is examined with one window read per predecessor, min(band_width, filled entries)
// reads through a single read port (none when there is nothing to examine), then the 9-stage
// scoring pipe drains; the next anchor is accepted only after this one reaches write-back.
// Reset empties the window counters; window contents stay undefined, never read unfilled.
// A stalled result holds in the output register; the next anchor is taken meanwhile,
// and its write-back waits until that result has left.

module anchor_chaining_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  acd_pkg::anchor_in_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output acd_pkg::chain_out_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [19:0]         cfg_wdata
);

  acd_pkg::state_t state_r, state_nxt;

  logic [7:0]  seed_r;
  logic [19:0] gap_r;
  logic [6:0]  band_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r     <= acd_pkg::SEED_RESET;
      gap_r      <= acd_pkg::GAP_RESET;
      band_cfg_r <= acd_pkg::BAND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        acd_pkg::CFG_SEED_LENGTH: seed_r     <= cfg_wdata[7:0];
        acd_pkg::CFG_MAX_GAP:     gap_r      <= cfg_wdata;
        acd_pkg::CFG_BAND_WIDTH:  band_cfg_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  acd_pkg::entry_t            cur_r, cur_nxt;
  logic [acd_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [acd_pkg::IDX_W-1:0]  slot_r, slot_nxt;
  logic [6:0]                 band_r, band_nxt;
  logic [6:0]                 d_r, d_nxt;
  logic signed [31:0]         best_r, best_nxt;
  logic [6:0]                 bestd_r, bestd_nxt;
  logic                       rd_vld_r, rd_vld_nxt;
  logic [6:0]                 rd_d_r;
  logic                       out_valid_r, out_valid_nxt;
  acd_pkg::chain_out_t        out_data_r, out_data_nxt;

  logic                       mem_we, mem_re;
  logic [acd_pkg::IDX_W-1:0]  rd_addr;
  acd_pkg::entry_t            wr_entry, rd_entry;
  acd_pkg::prop_res_t         pres;
  logic                       prop_busy;

  logic [acd_pkg::FILL_W-1:0] fill_eff;
  logic [acd_pkg::IDX_W-1:0]  slot_eff;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    fill_nxt      = fill_r;
    slot_nxt      = slot_r;
    band_nxt      = band_r;
    d_nxt         = d_r;
    best_nxt      = best_r;
    bestd_nxt     = bestd_r;
    rd_vld_nxt    = 1'b0;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    rd_addr       = slot_r - d_r[acd_pkg::IDX_W-1:0];
    wr_entry      = cur_r;
    wr_entry.score = best_r;
    fill_eff      = in_data.new_read ? '0 : fill_r;
    slot_eff      = in_data.new_read ? '0 : slot_r;
    in_stall      = (state_r != acd_pkg::ST_IDLE);

    // nearest candidate arrives first; keep only strictly better
    if (pres.vld && !pres.rej && (pres.s > best_r)) begin
      best_nxt  = pres.s;
      bestd_nxt = pres.cand_d;
    end

    unique case (state_r)
      acd_pkg::ST_IDLE: begin
        if (in_valid) begin
          cur_nxt.qb    = in_data.q_begin;
          cur_nxt.qe    = in_data.q_end;
          cur_nxt.tb    = in_data.t_begin;
          cur_nxt.te    = in_data.t_end;
          cur_nxt.score = '0;
          fill_nxt      = fill_eff;
          slot_nxt      = slot_eff;
          band_nxt      = (band_cfg_r < 7'(fill_eff)) ? band_cfg_r : 7'(fill_eff);
          d_nxt         = 7'd1;
          best_nxt      = $signed({14'd0, seed_r, 10'd0});
          bestd_nxt     = 7'd0;
          state_nxt     = (band_nxt == 7'd0) ? acd_pkg::ST_DRAIN : acd_pkg::ST_SCAN;
        end
      end
      acd_pkg::ST_SCAN: begin
        mem_re     = 1'b1;
        rd_vld_nxt = 1'b1;
        d_nxt      = d_r + 7'd1;
        if (d_r == band_r) state_nxt = acd_pkg::ST_DRAIN;
      end
      acd_pkg::ST_DRAIN: begin
        if (!rd_vld_r && !prop_busy) state_nxt = acd_pkg::ST_WRITE;
      end
      acd_pkg::ST_WRITE: begin
        if (!out_valid_r || !out_stall) begin
          mem_we                     = 1'b1;
          out_valid_nxt              = 1'b1;
          out_data_nxt.chain_score   = best_r;
          out_data_nxt.pred_distance = bestd_r;
          slot_nxt                   = slot_r + 1'b1;
          if (fill_r != acd_pkg::FILL_W'(acd_pkg::WINDOW)) fill_nxt = fill_r + 1'b1;
          state_nxt                  = acd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = acd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= acd_pkg::ST_IDLE;
      fill_r      <= '0;
      slot_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      slot_r      <= slot_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    band_r     <= band_nxt;
    d_r        <= d_nxt;
    best_r     <= best_nxt;
    bestd_r    <= bestd_nxt;
    rd_d_r     <= d_r;
    out_data_r <= out_data_nxt;
  end

  acd_window u_window (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (slot_r),
    .wr_data (wr_entry),
    .rd_en   (mem_re),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  acd_prop u_prop (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (rd_vld_r),
    .in_dist (rd_d_r),
    .pred    (rd_entry),
    .cur     (cur_r),
    .seed    (seed_r),
    .max_gap (gap_r),
    .res     (pres),
    .busy    (prop_busy)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= acd_pkg::FILL_W'(acd_pkg::WINDOW))
    else $error("window fill beyond depth");

  a_read_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r == acd_pkg::ST_SCAN))
    else $error("window read outside scan");

  a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == acd_pkg::ST_WRITE))
    else $error("result raised outside write-back");

  a_cand_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pres.vld |-> (state_r == acd_pkg::ST_SCAN || state_r == acd_pkg::ST_DRAIN))
    else $error("candidate score arrived outside an anchor");

endmodule

// ===== dv/tb_anchor_chaining_dp.sv =====
`timescale 1ns / 1ps

module tb_anchor_chaining_dp;

  localparam int           CYCLE_LIMIT = 3000000;
  localparam int           SETTLE      = 120;
  localparam int           N_RANDOM    = 60;
  localparam int           N_DIRECTED  = 12;
  localparam logic [1:0]   CFG_UNUSED  = 2'd3;
  localparam int unsigned  LOG_SEG[17] = '{
    0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
    42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536
  };

  typedef struct {
    acd_pkg::anchor_in_t a;
    bit                  typed;
    acd_pkg::chain_out_t res;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  acd_pkg::anchor_in_t in_data;
  logic                out_valid;
  logic                out_stall;
  acd_pkg::chain_out_t out_data;
  logic                cfg_we;
  logic [1:0]          cfg_addr;
  logic [19:0]         cfg_wdata;

  // predictor state
  longint unsigned win_qb[acd_pkg::WINDOW], win_qe[acd_pkg::WINDOW];
  longint unsigned win_tb[acd_pkg::WINDOW], win_te[acd_pkg::WINDOW];
  int              win_score[acd_pkg::WINDOW];
  int              fill_cnt, wr_slot;
  longint unsigned seed_len, gap_max, band;

  acd_pkg::chain_out_t score_q[$];
  dir_row_t            dir_tab[N_DIRECTED];
  int                  n_accepted, errors, cycles;
  int                  send_idle, recv_stall, hold_cycles;
  longint unsigned     run_q, run_t;

  anchor_chaining_dp i_dut (.*);

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic report(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic longint unsigned log2_fix(longint unsigned g);
    int unsigned     e;
    longint unsigned n, seg, rem;
    e = 0;
    while (e < 23 && (g >> (e + 1)) != 0) e++;
    n   = (g << (23 - e)) & 64'hFF_FFFF;
    seg = (n >> 19) & 15;
    rem = n & 64'h7_FFFF;
    return (longint'(e) << 16) + LOG_SEG[seg]
           + (((LOG_SEG[seg + 1] - LOG_SEG[seg]) * rem) >> 19);
  endfunction

  function automatic longint unsigned fwd_gap(longint unsigned later,
                                              longint unsigned earlier);
    return later >= earlier ? later - earlier : 64'hFFFF_FFFF_FFFF_FFFF;
  endfunction

  function automatic longint unsigned umin(longint unsigned x, longint unsigned y);
    return x < y ? x : y;
  endfunction

  function automatic acd_pkg::chain_out_t chain_predict(acd_pkg::anchor_in_t a);
    acd_pkg::chain_out_t r;
    longint              best, s;
    longint unsigned     ql, tl, g, m, ov, cost;
    int                  lim, slot, bestd;
    if (a.new_read) begin
      fill_cnt = 0;
      wr_slot  = 0;
    end
    best  = longint'(seed_len << acd_pkg::FRAC_BITS);
    bestd = 0;
    lim   = (band > fill_cnt) ? fill_cnt : int'(band);
    for (int d = 1; d <= lim; d++) begin
      slot = (wr_slot + acd_pkg::WINDOW - d) % acd_pkg::WINDOW;
      if (win_qe[slot] >= a.q_end) continue;
      ql = umin(fwd_gap(a.q_begin, win_qb[slot]), fwd_gap(a.q_end, win_qe[slot]));
      tl = umin(fwd_gap(a.t_begin, win_tb[slot]), fwd_gap(a.t_end, win_te[slot]));
      if (ql > gap_max || tl > gap_max) continue;
      g    = ql > tl ? ql - tl : tl - ql;
      cost = 0;
      if (g != 0) begin
        cost = ((seed_len * g << acd_pkg::FRAC_BITS) + 50) / 100;
        cost += (log2_fix(g) + (64'd1 << (16 - acd_pkg::FRAC_BITS)))
                >> (17 - acd_pkg::FRAC_BITS);
      end
      m  = umin(umin(ql, tl), seed_len);
      ov = win_qe[slot] > a.q_begin ? win_qe[slot] - a.q_begin : 0;
      if (ov > (64'd1 << 33)) ov = 64'd1 << 33;
      s = longint'(win_score[slot]) + longint'(m << acd_pkg::FRAC_BITS) - longint'(cost)
          + longint'(ov << acd_pkg::FRAC_BITS);
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      if (s > best) begin
        best  = s;
        bestd = d;
      end
    end
    win_qb[wr_slot]    = a.q_begin;
    win_qe[wr_slot]    = a.q_end;
    win_tb[wr_slot]    = a.t_begin;
    win_te[wr_slot]    = a.t_end;
    win_score[wr_slot] = int'(best);
    wr_slot = (wr_slot + 1) % acd_pkg::WINDOW;
    if (fill_cnt < acd_pkg::WINDOW) fill_cnt++;
    r.chain_score   = 32'(best);
    r.pred_distance = 7'(bestd);
    return r;
  endfunction

  // monitor: predict on accepted anchors, check accepted results
  always @(posedge clk) begin
    acd_pkg::chain_out_t exp_r;
    if (rst_n) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("DONE: errors detected");
        $finish;
      end else begin
        if (in_valid && !in_stall) begin
          exp_r = chain_predict(in_data);
          if (n_accepted < N_DIRECTED && dir_tab[n_accepted].typed &&
              exp_r != dir_tab[n_accepted].res)
            report($sformatf("directed row %0d: predictor gives %0d/%0d, table %0d/%0d",
                             n_accepted, exp_r.chain_score, exp_r.pred_distance,
                             dir_tab[n_accepted].res.chain_score,
                             dir_tab[n_accepted].res.pred_distance));
          score_q = {score_q, exp_r};
          n_accepted++;
        end
        if (out_valid && !out_stall) begin
          if (score_q.size() == 0) begin
            report("result with no anchor outstanding");
          end else begin
            exp_r = score_q.pop_front();
            if (out_data.chain_score !== exp_r.chain_score)
              report($sformatf("chain_score %0d, expected %0d",
                               out_data.chain_score, exp_r.chain_score));
            if (out_data.pred_distance !== exp_r.pred_distance)
              report($sformatf("pred_distance %0d, expected %0d",
                               out_data.pred_distance, exp_r.pred_distance));
          end
        end
      end
    end
  end

  // receiver: random stall, or a long hold counted here
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall = 1'b1;
      hold_cycles--;
    end else begin
      out_stall = ($urandom_range(99) < recv_stall);
    end
  end

  task automatic send(input acd_pkg::anchor_in_t a);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = a;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] addr, input logic [19:0] val);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = val;
    case (addr)
      acd_pkg::CFG_SEED_LENGTH: seed_len = val[7:0];
      acd_pkg::CFG_MAX_GAP:     gap_max  = val;
      acd_pkg::CFG_BAND_WIDTH:  band     = val[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (score_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic configure(input int seed, input int gap, input int bw);
    cfg_write(acd_pkg::CFG_SEED_LENGTH, 20'(seed));
    cfg_write(acd_pkg::CFG_MAX_GAP, 20'(gap));
    cfg_write(acd_pkg::CFG_BAND_WIDTH, 20'(bw));
  endtask

  // mostly well-formed chains with random content, some noise and read breaks
  function automatic acd_pkg::anchor_in_t rand_anchor(input int spread);
    acd_pkg::anchor_in_t a;
    int unsigned         len, pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      a = {$urandom, $urandom, $urandom, $urandom, 1'($urandom)};
    end else begin
      if (pick < 15) begin
        run_q = $urandom;
        run_t = $urandom;
      end
      len   = $urandom_range(1, 40);
      run_q = (run_q + $urandom_range(0, spread)) & 64'hFFFF_FFFF;
      run_t = (run_t + $urandom_range(0, spread)) & 64'hFFFF_FFFF;
      a.q_begin  = 32'(run_q);
      a.q_end    = 32'(run_q + len);
      a.t_begin  = 32'(run_t);
      a.t_end    = 32'(run_t + len + $urandom_range(0, 3) - 1);
      a.new_read = (pick < 15);
    end
    return a;
  endfunction

  task automatic random_phase(input int n, input int spread, input int idle,
                              input int stall);
    send_idle  = idle;
    recv_stall = stall;
    for (int i = 0; i < n; i++) send(rand_anchor(spread));
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = acd_pkg::CFG_SEED_LENGTH;
    cfg_wdata  = '0;
    errors     = 0;
    cycles     = 0;
    n_accepted = 0;
    send_idle  = 0;
    recv_stall = 0;
    hold_cycles = 0;
    fill_cnt   = 0;
    wr_slot    = 0;
    seed_len   = acd_pkg::SEED_RESET;
    gap_max    = acd_pkg::GAP_RESET;
    band       = acd_pkg::BAND_RESET;
    run_q      = 1000;
    run_t      = 5000;

    dir_tab = '{
      '{'{32'd0, 32'd10, 32'd0, 32'd10, 1'b1}, 1, '{32'sd17408, 7'd0}},
      '{'{32'd5, 32'd15, 32'd5, 32'd15, 1'b0}, 0, '{0, 0}},
      // same query end as previous: rejected
      '{'{32'd6, 32'd15, 32'd6, 32'd16, 1'b0}, 0, '{0, 0}},
      // query start goes backwards: that difference loses the minimum
      '{'{32'd2, 32'd30, 32'd20, 32'd40, 1'b0}, 0, '{0, 0}},
      // unequal gaps: cost and log term
      '{'{32'd300, 32'd320, 32'd40, 32'd60, 1'b0}, 0, '{0, 0}},
      // gap beyond limit
      '{'{32'd50000, 32'd50020, 32'd50000, 32'd50020, 1'b0}, 0, '{0, 0}},
      '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1,
        '{32'sd17408, 7'd0}},
      // lower query end than every stored anchor
      '{'{32'd0, 32'd0, 32'd0, 32'd0, 1'b0}, 1, '{32'sd17408, 7'd0}},
      '{'{32'hFFFF_FF00, 32'hFFFF_FF10, 32'hFFFF_FF00, 32'hFFFF_FF10, 1'b1}, 0, '{0, 0}},
      // large overlap with the previous anchor
      '{'{32'hFFFF_FF01, 32'hFFFF_FFF0, 32'hFFFF_FF01, 32'hFFFF_FFF0, 1'b0}, 0, '{0, 0}},
      '{'{32'hFFFF_FF02, 32'hFFFF_FFFE, 32'hFFFF_FF05, 32'hFFFF_FFF9, 1'b0}, 0, '{0, 0}},
      '{'{32'hAAAA_5555, 32'h5555_AAAA, 32'h0F0F_F0F0, 32'hF0F0_0F0F, 1'b1}, 1,
        '{32'sd17408, 7'd0}}
    };

    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) send(dir_tab[i].a);
    random_phase(N_RANDOM, 30, 0, 0);
    drain();

    configure(255, 1048575, 64);
    random_phase(N_RANDOM, 3000, 70, 0);
    drain();

    configure(1, 0, 1);
    random_phase(N_RANDOM, 2, 0, 70);
    drain();

    // seed zero and a band wider than the window
    configure(0, 500, 127);
    random_phase(N_RANDOM, 60, 34, 34);
    drain();

    configure(17, 10000, 0);
    random_phase(30, 30, 34, 34);
    drain();

    // hold the output long enough for the block to stall its input
    configure(40, 2000, 8);
    hold_cycles = 2000;
    random_phase(N_RANDOM, 30, 0, 0);
    drain();

    cfg_write(CFG_UNUSED, 20'hFFFFF);
    configure(acd_pkg::SEED_RESET, acd_pkg::GAP_RESET, acd_pkg::BAND_RESET);
    random_phase(N_RANDOM, 25, 20, 20);
    drain();

    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
design/acd_pkg.sv
design/acd_window.sv
design/acd_prop.sv
design/anchor_chaining_dp.sv
dv/tb_anchor_chaining_dp.sv
